>>> design/assert_macros.svh
// Assertion macros shared by the edge spring force block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a consequence in the same cycle
`define TESF_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// check a consequence a fixed number of cycles later
`define TESF_ASSERT_DLY(lbl, pre, n, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##n (post)) \
        else $error(msg);

`endif

>>> design/tesf_pkg.sv
// Types and constants of the triangle edge spring force block
package tesf_pkg;

    localparam int COORD_W    = 32;
    localparam int LEN_W      = 31;
    localparam int EDGE_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * EDGE_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = COORD_W + 2;
    localparam int DIFF_W     = ((ROOT_W > LEN_W) ? ROOT_W : LEN_W) + 1;
    localparam int COEF_W     = LEN_W + 1 + DIFF_W;
    localparam int FRAC_SHIFT = 32;
    localparam int LO_W       = FRAC_SHIFT + 1 + EDGE_W;
    localparam int HI_W       = COEF_W - FRAC_SHIFT;
    localparam int HP_W       = HI_W + EDGE_W;
    localparam int PROD_W     = COEF_W + EDGE_W;
    localparam int FSUM_W     = PROD_W + 1;
    localparam int Q_W        = FSUM_W - FRAC_SHIFT;

    localparam logic [LEN_W-1:0] GAIN_RESET = LEN_W'(65536);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [LEN_W-1:0]          len_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;

    typedef struct packed {
        coord_t vert_a_x;
        coord_t vert_a_y;
        coord_t vert_a_z;
        coord_t vert_b_x;
        coord_t vert_b_y;
        coord_t vert_b_z;
        coord_t vert_c_x;
        coord_t vert_c_y;
        coord_t vert_c_z;
        len_t   rest_ab;
        len_t   rest_bc;
        len_t   rest_ca;
    } face_t;

    typedef struct packed {
        coord_t force_a_x;
        coord_t force_a_y;
        coord_t force_a_z;
        coord_t force_b_x;
        coord_t force_b_y;
        coord_t force_b_z;
        coord_t force_c_x;
        coord_t force_c_y;
        coord_t force_c_z;
    } forces_t;

    typedef struct packed {
        edge_t [2:0][2:0] edges;
        len_t  [2:0]      rest;
    } edge_pl_t;

endpackage

>>> design/tesf_sqrt.sv
// Pipelined integer square root of three squared edge lengths, one root bit per stage
`include "assert_macros.svh"

module tesf_sqrt (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                val_in,
    input  logic [2:0][tesf_pkg::SUM_W-1:0]     sum_in,
    input  tesf_pkg::edge_pl_t                  pl_in,
    output logic                                val_out,
    output logic [2:0][tesf_pkg::ROOT_W-1:0]    root_out,
    output tesf_pkg::edge_pl_t                  pl_out
);
    import tesf_pkg::*;

    logic                               val_reg [ROOT_W];
    logic [2:0][SUM_W-1:0]              x_reg   [ROOT_W];
    logic [2:0][ROOT_W-1:0]             r_reg   [ROOT_W];
    edge_pl_t                           pl_reg  [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        localparam int B = ROOT_W - 1 - i;

        logic                  cur_val;
        logic [2:0][SUM_W-1:0] cur_x;
        logic [2:0][ROOT_W-1:0] cur_r;
        edge_pl_t              cur_pl;
        logic [2:0][SUM_W-1:0] x_next;
        logic [2:0][ROOT_W-1:0] r_next;

        if (i == 0) begin : g_first
            assign cur_val = val_in;
            assign cur_x   = sum_in;
            assign cur_r   = '0;
            assign cur_pl  = pl_in;
        end
        else begin : g_rest
            assign cur_val = val_reg[i-1];
            assign cur_x   = x_reg[i-1];
            assign cur_r   = r_reg[i-1];
            assign cur_pl  = pl_reg[i-1];
        end

        always_comb
        begin
            logic [SUM_W:0] trial;
            for (int e = 0; e < 3; e++)
            begin
                trial = ((SUM_W+1)'(cur_r[e]) << (B + 1)) | ((SUM_W+1)'(1) << (2 * B));
                if ((SUM_W+1)'(cur_x[e]) >= trial)
                begin
                    x_next[e] = SUM_W'((SUM_W+1)'(cur_x[e]) - trial);
                    r_next[e] = cur_r[e] | (ROOT_W'(1) << B);
                end
                else
                begin
                    x_next[e] = cur_x[e];
                    r_next[e] = cur_r[e];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                val_reg[i] <= 1'b0;
            else
                val_reg[i] <= cur_val;
        end

        always_ff @(posedge clk)
        begin
            x_reg[i]  <= x_next;
            r_reg[i]  <= r_next;
            pl_reg[i] <= cur_pl;
        end
    end

    assign val_out  = val_reg[ROOT_W-1];
    assign root_out = r_reg[ROOT_W-1];
    assign pl_out   = pl_reg[ROOT_W-1];

    `TESF_ASSERT_DLY(a_sqrt_lat, val_in, ROOT_W, val_out, "root lost in pipeline")
    `TESF_ASSERT_DLY(a_sqrt_nogen, !val_in, ROOT_W, !val_out, "root without operand")
    `TESF_ASSERT_IMP(a_sqrt_rem, val_out,
        (x_reg[ROOT_W-1][0] <= SUM_W'({r_reg[ROOT_W-1][0], 1'b0}))
        && (x_reg[ROOT_W-1][1] <= SUM_W'({r_reg[ROOT_W-1][1], 1'b0}))
        && (x_reg[ROOT_W-1][2] <= SUM_W'({r_reg[ROOT_W-1][2], 1'b0})),
        "root remainder too large")

endmodule

>>> design/triangle_edge_spring_force_top.sv
// Top level of the triangle edge spring force pipeline
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------
//  face in  | start, busy        | face (face_t)
//  force out| done (strobe)      | forces (forces_t)
//  gain cfg | gain_we            | gain_wdata (31 bits)
//
// One face enters per cycle; busy stays low, so a transaction is taken on every start.
// The pipeline depth is set mostly by the one-bit-per-stage square root; the other stages capture
// the face or hold edge differences, squares, sums, products, force differences or the output clamp.
// Reset clears only the valid bits and loads the gain with 1.0.
// Results appear for one cycle on done; there is no output stall.
`include "assert_macros.svh"

module triangle_edge_spring_force_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  tesf_pkg::face_t          face,
    output logic                     done,
    output tesf_pkg::forces_t        forces,
    input  logic                     gain_we,
    input  logic [tesf_pkg::LEN_W-1:0] gain_wdata
);
    import tesf_pkg::*;

    localparam int LATENCY = ROOT_W + 10;

    logic [LEN_W-1:0]   gain_reg;
    logic               v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic               done_reg;
    face_t              face0_reg;
    edge_pl_t           pl1_reg, pl2_reg, pl3_reg, sq_pl;
    logic [2:0][2:0][SQ_W-1:0] sq2_reg;
    logic [2:0][SUM_W-1:0] sum3_reg;
    logic               vq;
    logic [2:0][ROOT_W-1:0] root;
    logic signed [DIFF_W-1:0] diff4_reg [3];
    logic signed [COEF_W-1:0] coef5_reg [3];
    edge_t              e4_reg [3][3];
    edge_t              e5_reg [3][3];
    logic signed [LO_W-1:0]   lo6_reg [3][3];
    logic signed [HP_W-1:0]   hi6_reg [3][3];
    logic signed [PROD_W-1:0] c7_reg  [3][3];
    logic signed [FSUM_W-1:0] f8_reg  [3][3];
    forces_t            forces_reg;

    coord_t             p [3][3];
    edge_pl_t           pl1_next;
    forces_t            forces_next;
    coord_t             fo [3][3];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= GAIN_RESET;
        else if (gain_we)
            gain_reg <= gain_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start && !busy;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= vq;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            done_reg <= v8_reg;
        end
    end

    always_comb
    begin
        p[0][0] = face0_reg.vert_a_x;
        p[0][1] = face0_reg.vert_a_y;
        p[0][2] = face0_reg.vert_a_z;
        p[1][0] = face0_reg.vert_b_x;
        p[1][1] = face0_reg.vert_b_y;
        p[1][2] = face0_reg.vert_b_z;
        p[2][0] = face0_reg.vert_c_x;
        p[2][1] = face0_reg.vert_c_y;
        p[2][2] = face0_reg.vert_c_z;
        pl1_next.rest[0] = face0_reg.rest_ab;
        pl1_next.rest[1] = face0_reg.rest_bc;
        pl1_next.rest[2] = face0_reg.rest_ca;
        for (int e = 0; e < 3; e++)
            for (int ax = 0; ax < 3; ax++)
                pl1_next.edges[e][ax] = EDGE_W'(p[(e == 2) ? 0 : e + 1][ax])
                                      - EDGE_W'(p[e][ax]);
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            face0_reg <= face;
        pl1_reg <= pl1_next;
        pl2_reg <= pl1_reg;
        for (int e = 0; e < 3; e++)
            for (int ax = 0; ax < 3; ax++)
                sq2_reg[e][ax] <= SQ_W'(pl1_reg.edges[e][ax] * pl1_reg.edges[e][ax]);
        pl3_reg <= pl2_reg;
        for (int e = 0; e < 3; e++)
            sum3_reg[e] <= SUM_W'(sq2_reg[e][0]) + SUM_W'(sq2_reg[e][1])
                         + SUM_W'(sq2_reg[e][2]);
    end

    tesf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .val_in   (v3_reg),
        .sum_in   (sum3_reg),
        .pl_in    (pl3_reg),
        .val_out  (vq),
        .root_out (root),
        .pl_out   (sq_pl)
    );

    always_ff @(posedge clk)
    begin
        for (int e = 0; e < 3; e++)
        begin
            diff4_reg[e] <= $signed({1'b0, root[e]}) - $signed({1'b0, sq_pl.rest[e]});
            coef5_reg[e] <= $signed({1'b0, gain_reg}) * diff4_reg[e];
            for (int ax = 0; ax < 3; ax++)
            begin
                e4_reg[e][ax]  <= sq_pl.edges[e][ax];
                e5_reg[e][ax]  <= e4_reg[e][ax];
                lo6_reg[e][ax] <= $signed({1'b0, coef5_reg[e][FRAC_SHIFT-1:0]}) * e5_reg[e][ax];
                hi6_reg[e][ax] <= $signed(coef5_reg[e][COEF_W-1:FRAC_SHIFT]) * e5_reg[e][ax];
                c7_reg[e][ax]  <= (PROD_W'(hi6_reg[e][ax]) <<< FRAC_SHIFT)
                                + PROD_W'(lo6_reg[e][ax]);
            end
        end
        for (int v = 0; v < 3; v++)
            for (int ax = 0; ax < 3; ax++)
                f8_reg[v][ax] <= FSUM_W'(c7_reg[v][ax])
                               - FSUM_W'(c7_reg[(v == 0) ? 2 : v - 1][ax]);
    end

    always_comb
    begin
        logic signed [Q_W-1:0] q;
        for (int v = 0; v < 3; v++)
            for (int ax = 0; ax < 3; ax++)
            begin
                q = Q_W'(f8_reg[v][ax] >>> FRAC_SHIFT);
                if (q > Q_W'(signed'({1'b0, {(COORD_W-1){1'b1}}})))
                    fo[v][ax] = {1'b0, {(COORD_W-1){1'b1}}};
                else if (q < -Q_W'(signed'({1'b0, 1'b1, {(COORD_W-1){1'b0}}})))
                    fo[v][ax] = {1'b1, {(COORD_W-1){1'b0}}};
                else
                    fo[v][ax] = COORD_W'(q);
            end
        forces_next.force_a_x = fo[0][0];
        forces_next.force_a_y = fo[0][1];
        forces_next.force_a_z = fo[0][2];
        forces_next.force_b_x = fo[1][0];
        forces_next.force_b_y = fo[1][1];
        forces_next.force_b_z = fo[1][2];
        forces_next.force_c_x = fo[2][0];
        forces_next.force_c_y = fo[2][1];
        forces_next.force_c_z = fo[2][2];
    end

    always_ff @(posedge clk)
    begin
        forces_reg <= forces_next;
    end

    assign done   = done_reg;
    assign forces = forces_reg;

    `TESF_ASSERT_DLY(a_latency, start && !busy, LATENCY, done, "face result missing")
    `TESF_ASSERT_IMP(a_momentum_x, v8_reg,
        (FSUM_W+2)'(f8_reg[0][0]) + (FSUM_W+2)'(f8_reg[1][0]) + (FSUM_W+2)'(f8_reg[2][0]) == 0,
        "x forces do not cancel")
    `TESF_ASSERT_IMP(a_momentum_yz, v8_reg,
        ((FSUM_W+2)'(f8_reg[0][1]) + (FSUM_W+2)'(f8_reg[1][1]) + (FSUM_W+2)'(f8_reg[2][1]) == 0)
        && ((FSUM_W+2)'(f8_reg[0][2]) + (FSUM_W+2)'(f8_reg[1][2])
            + (FSUM_W+2)'(f8_reg[2][2]) == 0),
        "y or z forces do not cancel")

endmodule

>>> bench/triangle_edge_spring_force_top_test.sv
// Testbench for the triangle edge spring force pipeline: random faces checked against a predictor
`timescale 1ns / 1ps

module triangle_edge_spring_force_top_test;
    import tesf_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    face_t face;
    logic done;
    forces_t forces;
    logic gain_we;
    len_t gain_wdata;

    face_t pending_faces[$];
    forces_t expected_forces[$];
    len_t gain_model;
    int gap_left;
    int idle_mode;
    bit start_taken;
    bit failed;

    triangle_edge_spring_force_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .face       (face),
        .done       (done),
        .forces     (forces),
        .gain_we    (gain_we),
        .gain_wdata (gain_wdata)
    );

    always #2 clk = ~clk;

    function automatic forces_t spring_forces(face_t f, len_t k);
        logic signed [33:0] p[3][3];
        logic signed [33:0] d[3];
        logic signed [71:0] dw;
        logic [71:0] sq;
        logic [71:0] c;
        logic [71:0] r;
        logic signed [39:0] diff;
        logic signed [127:0] acc[3][3];
        logic signed [127:0] kw;
        logic signed [127:0] prod;
        logic signed [127:0] q;
        len_t rest[3];
        logic [9*32-1:0] o;
        int e;
        int ax;
        int b;
        int nx;
        p[0][0] = f.vert_a_x; p[0][1] = f.vert_a_y; p[0][2] = f.vert_a_z;
        p[1][0] = f.vert_b_x; p[1][1] = f.vert_b_y; p[1][2] = f.vert_b_z;
        p[2][0] = f.vert_c_x; p[2][1] = f.vert_c_y; p[2][2] = f.vert_c_z;
        rest[0] = f.rest_ab; rest[1] = f.rest_bc; rest[2] = f.rest_ca;
        kw = k;
        for (e = 0; e < 3; e++)
            for (ax = 0; ax < 3; ax++)
                acc[e][ax] = 0;
        for (e = 0; e < 3; e++)
        begin
            nx = (e + 1) % 3;
            sq = 0;
            for (ax = 0; ax < 3; ax++)
            begin
                d[ax] = p[nx][ax] - p[e][ax];
                dw = d[ax];
                sq = sq + 72'(dw * dw);
            end
            r = 0;
            for (b = 33; b >= 0; b--)
            begin
                c = r | (72'(1) << b);
                if (c * c <= sq)
                    r = c;
            end
            diff = 40'(r) - 40'(rest[e]);
            for (ax = 0; ax < 3; ax++)
            begin
                prod = kw * 128'(diff) * 128'(d[ax]);
                acc[e][ax] = acc[e][ax] + prod;
                acc[nx][ax] = acc[nx][ax] - prod;
            end
        end
        for (e = 0; e < 3; e++)
            for (ax = 0; ax < 3; ax++)
            begin
                q = acc[e][ax] >>> 32;
                if (q > 128'sd2147483647)
                    q = 128'sd2147483647;
                else if (q < -128'sd2147483648)
                    q = -128'sd2147483648;
                o[(8 - (e * 3 + ax)) * 32 +: 32] = q[31:0];
            end
        return forces_t'(o);
    endfunction

    function automatic coord_t rand_coord(int span);
        if (span >= 32)
            return coord_t'($urandom);
        return coord_t'($signed($urandom_range(0, (1 << (span + 1)) - 1)) - (1 << span));
    endfunction

    function automatic face_t rand_face(int span, bit near_rest);
        face_t f;
        f.vert_a_x = rand_coord(span); f.vert_a_y = rand_coord(span);
        f.vert_a_z = rand_coord(span); f.vert_b_x = rand_coord(span);
        f.vert_b_y = rand_coord(span); f.vert_b_z = rand_coord(span);
        f.vert_c_x = rand_coord(span); f.vert_c_y = rand_coord(span);
        f.vert_c_z = rand_coord(span);
        if (near_rest)
        begin
            f.rest_ab = len_t'($urandom_range(0, (1 << (span + 1)) - 1));
            f.rest_bc = len_t'($urandom_range(0, (1 << (span + 1)) - 1));
            f.rest_ca = len_t'($urandom_range(0, (1 << (span + 1)) - 1));
        end
        else
        begin
            f.rest_ab = len_t'($urandom);
            f.rest_bc = len_t'($urandom);
            f.rest_ca = len_t'($urandom);
        end
        if ($urandom_range(0, 15) == 0)
        begin
            f.vert_b_x = f.vert_a_x; f.vert_b_y = f.vert_a_y; f.vert_b_z = f.vert_a_z;
        end
        return f;
    endfunction

    task automatic set_gain(len_t k);
        wait (pending_faces.size() == 0 && expected_forces.size() == 0 && !start);
        repeat (50) @(negedge clk);
        gain_we <= 1'b1;
        gain_wdata <= k;
        @(negedge clk);
        gain_we <= 1'b0;
        gain_model = k;
    endtask

    // drive one transaction per draw of the idle gap
    always @(negedge clk)
    begin
        if (!(start && !start_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_faces.size() > 0)
            begin
                face <= pending_faces.pop_front();
                start <= 1'b1;
                gap_left <= idle_mode ? $urandom_range(0, 18) : 0;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        start_taken = rst_n && start && !busy;
        if (start_taken)
            expected_forces.push_back(spring_forces(face, gain_model));
        if (rst_n && done)
        begin
            if (expected_forces.size() == 0)
            begin
                $error("unexpected result");
                failed = 1'b1;
            end
            else
            begin
                forces_t ex;
                string names[9];
                ex = expected_forces.pop_front();
                names = '{"force_a_x", "force_a_y", "force_a_z", "force_b_x", "force_b_y",
                          "force_b_z", "force_c_x", "force_c_y", "force_c_z"};
                for (int i = 0; i < 9; i++)
                    if (ex[(8 - i) * 32 +: 32] !== forces[(8 - i) * 32 +: 32])
                    begin
                        $error("%s expected %0d actual %0d", names[i],
                               $signed(ex[(8 - i) * 32 +: 32]),
                               $signed(forces[(8 - i) * 32 +: 32]));
                        failed = 1'b1;
                    end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        face_t f;
        len_t gains[7];
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        face = '0;
        gain_we = 1'b0;
        gain_wdata = '0;
        gap_left = 0;
        idle_mode = 0;
        failed = 1'b0;
        gain_model = GAIN_RESET;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        pending_faces.push_back('0);
        f = '1;
        pending_faces.push_back(f);
        f = '0;
        f.vert_a_x = 32'sh80000000; f.vert_a_y = 32'sh80000000; f.vert_a_z = 32'sh80000000;
        f.vert_b_x = 32'sh7fffffff; f.vert_b_y = 32'sh7fffffff; f.vert_b_z = 32'sh7fffffff;
        pending_faces.push_back(f);
        f.rest_ab = '1; f.rest_bc = '1; f.rest_ca = '1;
        pending_faces.push_back(f);
        f = '0;
        f.vert_b_x = 32'sh00010000; f.vert_c_y = 32'sh00010000;
        pending_faces.push_back(f);
        f.rest_ab = len_t'(32'h00010000); f.rest_bc = len_t'(32'h00016a09);
        f.rest_ca = len_t'(32'h00010000);
        pending_faces.push_back(f);
        f = '0;
        f.rest_ab = '1; f.rest_bc = len_t'(32'h00050000); f.rest_ca = '1;
        pending_faces.push_back(f);
        f = rand_face(20, 1'b1);
        f.vert_c_x = f.vert_a_x; f.vert_c_y = f.vert_a_y; f.vert_c_z = f.vert_a_z;
        pending_faces.push_back(f);
        for (int i = 0; i < 12; i++)
            pending_faces.push_back(rand_face(i < 6 ? 32 : 10 + 2 * i, i[0]));

        gains = '{len_t'(0), '1, len_t'(1), len_t'(32'h00008000), len_t'(32'h00010000),
                  len_t'($urandom), len_t'($urandom_range(0, 32'h00100000))};
        for (int ph = 0; ph < 7; ph++)
        begin
            set_gain(gains[ph]);
            idle_mode = ph % 3 != 0;
            for (int i = 0; i < 140; i++)
                pending_faces.push_back(rand_face($urandom_range(0, 3) == 0 ? 32 :
                                                  $urandom_range(4, 30),
                                                  $urandom_range(0, 3) != 0));
        end

        wait (pending_faces.size() == 0 && !start && expected_forces.size() == 0);
        repeat (60) @(posedge clk);
        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
